// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/fgst_pkg.sv
package fgst_pkg;

   // Operation codes of an input item.
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_DRAIN      = 1'b1;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_REGION   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_NATION   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_CATEGORY = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YEAR_BASE      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CITY_BASE      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BRAND_BASE     = 3'd5;

   // Register reset values.
   localparam logic [7:0]  RESET_YEAR_BASE_LO = 8'd0;
   localparam logic [15:0] RESET_YEAR_BASE    = 16'd1997;
   localparam logic [7:0]  RESET_CITY_BASE    = 8'd230;
   localparam logic [15:0] RESET_BRAND_BASE   = 16'd120;

   typedef struct packed {
      logic        op;
      logic [7:0]  region_code;
      logic [7:0]  nation_code;
      logic [7:0]  category_code;
      logic [15:0] row_year;
      logic [7:0]  city_code;
      logic [15:0] brand_code;
      logic [31:0] revenue;
      logic [31:0] supply_cost;
   } req_payload_type;

   typedef struct packed {
      logic               entry_valid;
      logic [15:0]        group_year;
      logic [7:0]         group_city;
      logic [15:0]        group_brand;
      logic signed [63:0] group_profit;
      logic               last_entry;
   } rsp_payload_type;

   // One table entry: seen flag and running sum.
   typedef struct packed {
      logic        seen;
      logic [63:0] sum;
   } entry_type;

endpackage

// File: sv/fgst_chan_if.sv
interface fgst_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/filtered_group_sum_table.sv
// Filtered group-by-sum table. Rows (op accumulate) that match the configured region,
// nation and category codes, fall in year_base or the year after, and whose city and brand
// offsets fit their key fields add revenue minus supply cost into a table entry indexed by
// {year offset, city offset, brand offset}; other rows are dropped silently. A drain item
// (op drain) returns the entry at an internal cursor, clears it and advances the cursor, so
// successive drains walk the groups in sorted order and flag the final index. The table
// memory is read at the edge that accepts the item and written back in the write-back state
// that follows, and the next item is taken only after that write-back. A drain also waits
// in write-back while the previous result is still untaken. After reset the block runs a
// clearing pass over all TABLE_ENTRIES entries (2048 by default) and accepts no item until
// it ends; configuration writes are taken at any time but should only come while the block
// is idle.
`include "assert_macros.svh"

module filtered_group_sum_table import fgst_pkg::*; #(
   parameter int TABLE_ENTRIES = 2048,
   parameter int BRAND_BITS    = 6,
   parameter int CITY_BITS     = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   fgst_chan_if.sink                 req_ch,
   fgst_chan_if.source               rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int KW = CITY_BITS + BRAND_BITS + 1;
   localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_ENTRIES - 1);
   localparam logic [31:0]   CITY_MASK  = 32'((1 << CITY_BITS) - 1);
   localparam logic [31:0]   BRAND_MASK = 32'((1 << BRAND_BITS) - 1);

   // Sequencer codes.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WORK  = 2'd2;

   // Configuration registers.
   logic [7:0]  match_region_ff, match_nation_ff, match_category_ff, city_base_ff;
   logic [15:0] year_base_ff, brand_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_region_ff   <= RESET_YEAR_BASE_LO;
         match_nation_ff   <= RESET_YEAR_BASE_LO;
         match_category_ff <= RESET_YEAR_BASE_LO;
         year_base_ff      <= RESET_YEAR_BASE;
         city_base_ff      <= RESET_CITY_BASE;
         brand_base_ff     <= RESET_BRAND_BASE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MATCH_REGION:   match_region_ff   <= csr_wdata[7:0];
            CSR_MATCH_NATION:   match_nation_ff   <= csr_wdata[7:0];
            CSR_MATCH_CATEGORY: match_category_ff <= csr_wdata[7:0];
            CSR_YEAR_BASE:      year_base_ff      <= csr_wdata;
            CSR_CITY_BASE:      city_base_ff      <= csr_wdata[7:0];
            CSR_BRAND_BASE:     brand_base_ff     <= csr_wdata;
            default: ;  // writes to unknown indexes are dropped
         endcase
      end
   end

   // Control state.
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Item held during write-back.
   logic          is_drain_ff;
   logic          hit_ff;
   logic [AW-1:0] addr_ff;
   logic [63:0]   delta_ff;
   entry_type     rd_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Table memory.
   entry_type     table_mem [TABLE_ENTRIES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic req_fire;
   logic advance;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // A drain leaves write-back only once the output register is free.
   assign advance = !is_drain_ff || !rsp_valid_ff || rsp_ch.ready;

   // Row filter and key packing, evaluated on the item being accepted.
   logic [16:0] ydiff;
   logic [8:0]  cdiff;
   logic [16:0] bdiff;
   logic [KW-1:0] key;
   logic [31:0] key32;
   logic        row_hit;
   logic [63:0] row_delta;

   always_comb begin
      ydiff = {1'b0, req_ch.payload.row_year} - {1'b0, year_base_ff};
      cdiff = {1'b0, req_ch.payload.city_code} - {1'b0, city_base_ff};
      bdiff = {1'b0, req_ch.payload.brand_code} - {1'b0, brand_base_ff};
      key   = {ydiff[0], cdiff[CITY_BITS-1:0], bdiff[BRAND_BITS-1:0]};
      key32 = 32'(key);
      row_hit = (req_ch.payload.region_code == match_region_ff)
             && (req_ch.payload.nation_code == match_nation_ff)
             && (req_ch.payload.category_code == match_category_ff)
             && !ydiff[16] && (ydiff[15:1] == 15'd0)
             && !cdiff[8] && ((cdiff[7:0] >> CITY_BITS) == 8'd0)
             && !bdiff[16] && ((bdiff[15:0] >> BRAND_BITS) == 16'd0)
             && (key32 < 32'(TABLE_ENTRIES));
      row_delta = {32'd0, req_ch.payload.revenue} - {32'd0, req_ch.payload.supply_cost};
      mem_raddr = (req_ch.payload.op == OP_DRAIN) ? cursor_ff : key32[AW-1:0];
   end

   // Drain result decoded from the cursor.
   logic [31:0] cur32;

   always_comb begin
      cur32 = 32'(cursor_ff);
      rsp_data_in.entry_valid  = rd_ff.seen;
      rsp_data_in.group_year   = year_base_ff + 16'(cur32 >> (CITY_BITS + BRAND_BITS));
      rsp_data_in.group_city   = city_base_ff + 8'((cur32 >> BRAND_BITS) & CITY_MASK);
      rsp_data_in.group_brand  = brand_base_ff + 16'(cur32 & BRAND_MASK);
      rsp_data_in.group_profit = rd_ff.sum;
      rsp_data_in.last_entry   = (cursor_ff == LAST_IDX);
   end

   // Sequencer and memory write port.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == LAST_IDX) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_WORK;
         end
         ST_WORK: begin
            if (is_drain_ff) begin
               if (advance) begin
                  // Report the entry, clear it, advance the cursor.
                  mem_we       = 1'b1;
                  mem_waddr    = cursor_ff;
                  rsp_valid_in = 1'b1;
                  cursor_in    = (cursor_ff == LAST_IDX) ? '0 : cursor_ff + 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               // Fold the row into its entry; dropped rows write nothing.
               mem_we         = hit_ff;
               mem_wdata.seen = 1'b1;
               mem_wdata.sum  = rd_ff.sum + delta_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item registers, loaded at acceptance.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         is_drain_ff <= (req_ch.payload.op == OP_DRAIN);
         hit_ff      <= row_hit;
         addr_ff     <= key32[AW-1:0];
         delta_ff    <= row_delta;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WORK && is_drain_ff && advance) rsp_data_ff <= rsp_data_in;
   end

   // Table memory: registered read at acceptance, one write port.
   always_ff @(posedge clock) begin
      if (req_fire) rd_ff <= table_mem[mem_raddr];
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   `ASSERT_SAME(a_no_write_idle, state_ff == ST_IDLE, !mem_we, "table written while idle")
   `ASSERT_SAME(a_clr_only_clearing, state_ff != ST_CLEAR, clr_ff == '0,
                "clear counter moved outside the clearing pass")
   `ASSERT_NEXT(a_drain_gives_result, state_ff == ST_WORK && is_drain_ff && advance,
                rsp_valid_ff && state_ff == ST_IDLE, "drain write-back produced no result")
   `ASSERT_NEXT(a_accept_goes_work, req_fire, state_ff == ST_WORK,
                "accepted item did not enter write-back")

endmodule

// File: test/filtered_group_sum_table_test.sv
module filtered_group_sum_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fgst_pkg::*;

   // Table geometry, kept equal to the block's defaults.
   localparam int TABLE_ENTRIES = 2048;
   localparam int BRAND_BITS    = 6;
   localparam int CITY_BITS     = 4;

   // Random rows per configuration phase, and the number of such phases.
   localparam int PHASE_ITEMS   = 165;
   localparam int RANDOM_PHASES = 6;

   // Drains in the closing run, each with a one-in-four chance of a random item behind it.
   localparam int SWEEP_DRAINS  = 64;

   // Quiet cycles after the last result before a register write or the end.
   // Rows cause no result, so give the last write-back time to land.
   localparam int SETTLE_CYCLES = 8;

   // Cycles without any handshake before the run is declared hung. The longest
   // legitimate quiet stretch is the clearing pass after reset.
   localparam int WATCHDOG_LIMIT = 10 * TABLE_ENTRIES;

   // Print no more than this many mismatch lines; keep counting beyond it.
   localparam int REPORT_CAP = 200;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   fgst_chan_if #(.payload_type(req_payload_type)) req_ch ();
   fgst_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   filtered_group_sum_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .BRAND_BITS   (BRAND_BITS),
      .CITY_BITS    (CITY_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow of the filter and key registers, starting at their reset values.
   logic [7:0]  cfg_region   = '0;
   logic [7:0]  cfg_nation   = '0;
   logic [7:0]  cfg_category = '0;
   logic [15:0] cfg_year     = RESET_YEAR_BASE;
   logic [7:0]  cfg_city     = RESET_CITY_BASE;
   logic [15:0] cfg_brand    = RESET_BRAND_BASE;

   // Shadow of the group table and its drain cursor (2-state, so cleared at start).
   bit          slot_seen [TABLE_ENTRIES];
   bit [63:0]   slot_sum  [TABLE_ENTRIES];
   int unsigned drain_slot = 0;

   // Items waiting for the driver, and drained groups waiting to come out.
   req_payload_type pending_items   [$];
   rsp_payload_type expected_groups [$];

   // Where the drain cursor will stand once everything queued so far is taken;
   // used only to aim generated rows at entries that will be drained soon.
   int unsigned plan_cursor = 0;

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;

   // Pacing state of both sides. A calm side runs without gaps for a while.
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("mismatch at %0t ns: %s", $realtime, what);
   endtask

   // Advance the shadow table by one accepted item. A drain queues the group
   // it reports; a row either folds into its entry or is dropped.
   function automatic void predict_table(input req_payload_type it);
      int          year_off;
      int          city_off;
      int          brand_off;
      int unsigned slot;
      rsp_payload_type grp;
      if (it.op == OP_DRAIN) begin
         slot             = drain_slot;
         grp.entry_valid  = slot_seen[slot];
         grp.group_year   = cfg_year + 16'(slot >> (CITY_BITS + BRAND_BITS));
         grp.group_city   = cfg_city + 8'((slot >> BRAND_BITS) & ((1 << CITY_BITS) - 1));
         grp.group_brand  = cfg_brand + 16'(slot & ((1 << BRAND_BITS) - 1));
         grp.group_profit = slot_sum[slot];
         grp.last_entry   = (slot == TABLE_ENTRIES - 1);
         slot_seen[slot]  = 1'b0;
         slot_sum[slot]   = '0;
         drain_slot       = (slot + 1) % TABLE_ENTRIES;
         expected_groups.push_back(grp);
         return;
      end
      if (it.region_code != cfg_region || it.nation_code != cfg_nation ||
          it.category_code != cfg_category)
         return;
      // Offsets in plain integers: base plus one must not wrap at the top year.
      year_off  = int'(it.row_year) - int'(cfg_year);
      city_off  = int'(it.city_code) - int'(cfg_city);
      brand_off = int'(it.brand_code) - int'(cfg_brand);
      if (year_off < 0 || year_off > 1) return;
      if (city_off < 0 || city_off >= (1 << CITY_BITS)) return;
      if (brand_off < 0 || brand_off >= (1 << BRAND_BITS)) return;
      slot = (year_off << (CITY_BITS + BRAND_BITS)) | (city_off << BRAND_BITS) | brand_off;
      if (slot >= TABLE_ENTRIES) return;
      slot_seen[slot] = 1'b1;
      slot_sum[slot]  = slot_sum[slot] + ({32'd0, it.revenue} - {32'd0, it.supply_cost});
   endfunction

   task automatic compare_group(input rsp_payload_type got, input rsp_payload_type want);
      if (got.entry_valid !== want.entry_valid)
         flag_mismatch($sformatf("entry_valid got %0b want %0b",
                                 got.entry_valid, want.entry_valid));
      if (got.group_year !== want.group_year)
         flag_mismatch($sformatf("group_year got %0d want %0d",
                                 got.group_year, want.group_year));
      if (got.group_city !== want.group_city)
         flag_mismatch($sformatf("group_city got %0d want %0d",
                                 got.group_city, want.group_city));
      if (got.group_brand !== want.group_brand)
         flag_mismatch($sformatf("group_brand got %0d want %0d",
                                 got.group_brand, want.group_brand));
      if (got.group_profit !== want.group_profit)
         flag_mismatch($sformatf("group_profit got %0d want %0d",
                                 got.group_profit, want.group_profit));
      if (got.last_entry !== want.last_entry)
         flag_mismatch($sformatf("last_entry got %0b want %0b",
                                 got.last_entry, want.last_entry));
   endtask

   // Build one accumulate item with every field spelled out.
   function automatic req_payload_type make_row(input logic [7:0] region, nation, category,
                                                input logic [15:0] year,
                                                input logic [7:0] city,
                                                input logic [15:0] brand,
                                                input logic [31:0] revenue, cost);
      req_payload_type it;
      it.op            = OP_ACCUMULATE;
      it.region_code   = region;
      it.nation_code   = nation;
      it.category_code = category;
      it.row_year      = year;
      it.city_code     = city;
      it.brand_code    = brand;
      it.revenue       = revenue;
      it.supply_cost   = cost;
      return it;
   endfunction

   // Draw one item for the current settings. Most rows pass the filter and
   // land just ahead of the drain cursor, so their sums come back soon; the
   // rest break one condition or are pure noise. A drain carries junk fields.
   function automatic req_payload_type next_item(input bit drain_only);
      req_payload_type it;
      int unsigned     slot;
      int unsigned     pick;
      {it.region_code, it.nation_code, it.category_code, it.city_code} = $urandom;
      {it.row_year, it.brand_code} = $urandom;
      it.revenue     = $urandom;
      it.supply_cost = $urandom;
      pick = drain_only ? 0 : $urandom_range(0, 99);
      if (pick < 45) begin
         it.op       = OP_DRAIN;
         plan_cursor = (plan_cursor + 1) % TABLE_ENTRIES;
         return it;
      end
      it.op = OP_ACCUMULATE;
      if (pick >= 90) return it;
      if ($urandom_range(0, 4) == 0)
         slot = $urandom_range(0, TABLE_ENTRIES - 1);
      else
         slot = (plan_cursor + $urandom_range(0, 47)) % TABLE_ENTRIES;
      it.region_code   = cfg_region;
      it.nation_code   = cfg_nation;
      it.category_code = cfg_category;
      it.row_year      = cfg_year + 16'(slot >> (CITY_BITS + BRAND_BITS));
      it.city_code     = cfg_city + 8'((slot >> BRAND_BITS) & ((1 << CITY_BITS) - 1));
      it.brand_code    = cfg_brand + 16'(slot & ((1 << BRAND_BITS) - 1));
      // Break one condition of the filter now and then.
      if (pick >= 80) begin
         case ($urandom_range(0, 5))
            0: it.region_code   ^= 8'(1 << $urandom_range(0, 7));
            1: it.nation_code   ^= 8'(1 << $urandom_range(0, 7));
            2: it.category_code ^= 8'(1 << $urandom_range(0, 7));
            3: it.row_year      = cfg_year + 16'd2;
            4: it.city_code     = cfg_city - 8'd1;
            default: it.brand_code = cfg_brand + 16'(1 << BRAND_BITS);
         endcase
      end
      // Push the amounts to their extremes at times.
      case ($urandom_range(0, 7))
         0: it.revenue     = '1;
         1: it.supply_cost = '1;
         2: it.revenue     = '0;
         default: ;
      endcase
      return it;
   endfunction

   // Write one register and mirror it in the shadow copy.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_MATCH_REGION:   cfg_region   = data[7:0];
         CSR_MATCH_NATION:   cfg_nation   = data[7:0];
         CSR_MATCH_CATEGORY: cfg_category = data[7:0];
         CSR_YEAR_BASE:      cfg_year     = data;
         CSR_CITY_BASE:      cfg_city     = data[7:0];
         CSR_BRAND_BASE:     cfg_brand    = data;
         default: ;
      endcase
   endtask

   // Rewrite every register, back to back, then drop the write enable.
   task automatic apply_settings(input logic [7:0] region, nation, category,
                                 input logic [15:0] year,
                                 input logic [7:0] city,
                                 input logic [15:0] brand);
      write_reg(CSR_MATCH_REGION, 16'(region));
      write_reg(CSR_MATCH_NATION, 16'(nation));
      write_reg(CSR_MATCH_CATEGORY, 16'(category));
      write_reg(CSR_YEAR_BASE, year);
      write_reg(CSR_CITY_BASE, 16'(city));
      write_reg(CSR_BRAND_BASE, brand);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued item is taken and every drained group has come
   // out, then let the last row's write-back finish.
   task automatic settle();
      @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_groups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: present queued items, with a random gap after each one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait     <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_wait != 0) begin
            req_ch.valid <= 1'b0;
            req_wait     <= req_wait - 1;
         end else if (pending_items.size() != 0) begin
            req_ch.valid   <= 1'b1;
            req_ch.payload <= pending_items.pop_front();
            if ($urandom_range(0, 39) == 0) req_calm <= !req_calm;
            req_wait <= req_calm ? 0 : $urandom_range(0, 3);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side: after each taken result, stall for a random number of
   // cycles in which a result is on offer.
   always @(posedge clock) begin : result_pacing
      int unsigned stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if ($urandom_range(0, 39) == 0) rsp_calm <= !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 3);
         rsp_wait     <= stall;
         rsp_ch.ready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         if (rsp_ch.valid) begin
            rsp_wait     <= rsp_wait - 1;
            rsp_ch.ready <= (rsp_wait == 1);
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: check taken results against the oldest drained group first,
   // then fold a newly taken item into the shadow table.
   always @(posedge clock) begin : group_monitor
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_groups.size() == 0) begin
            flag_mismatch("result with no drain waiting for it");
         end else begin
            want = expected_groups.pop_front();
            compare_group(rsp_ch.payload, want);
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) predict_table(req_ch.payload);
   end

   // Count cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      clock          = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_MATCH_REGION;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. The first items wait out the clearing pass.
      // Entry 0: largest revenue, then largest cost, then a small loss.
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand, '0, '1));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand, 32'd5, 32'd9));
      // Filter misses aimed at entry 1, so that it drains empty.
      pending_items.push_back(make_row(8'hff, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, 8'hff, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, 8'hff, cfg_year,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year - 16'd1,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year + 16'd2,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, 16'd0,
                                       cfg_city, cfg_brand + 16'd1, '1, '0));
      // Offsets out of their fields: below the base, or one past the top.
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city - 8'd1, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city + 8'd16, cfg_brand + 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand - 16'd1, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd64, '1, '0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city + 8'd1, 16'hffff, '1, '0));
      // Highest key: second year, top city and brand offsets.
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year + 16'd1,
                                       cfg_city + 8'd15, cfg_brand + 16'd63,
                                       32'd1000, 32'd1));
      // Drains between rows: entry 0 full, entry 1 empty, entry 2 filled and
      // drained, then hit again behind the cursor, then entry 3.
      pending_items.push_back(next_item(1'b1));
      pending_items.push_back(next_item(1'b1));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd2, 32'd7, 32'd3));
      pending_items.push_back(next_item(1'b1));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd2, 32'd11, 32'd0));
      pending_items.push_back(make_row(cfg_region, cfg_nation, cfg_category, cfg_year,
                                       cfg_city, cfg_brand + 16'd3, 32'd0, 32'd42));
      pending_items.push_back(next_item(1'b1));
      settle();

      // Top settings. At the top year only that year passes; year 0 must not
      // pass as a wrapped year after it. Drains decode keys with wrapped sums.
      apply_settings(8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 16'hffff);
      pending_items.push_back(make_row(8'hff, 8'hff, 8'hff, 16'hffff, 8'hff, 16'hffff,
                                       32'd123, 32'd456));
      pending_items.push_back(make_row(8'hff, 8'hff, 8'hff, 16'd0, 8'hff, 16'hffff,
                                       '1, '0));
      pending_items.push_back(next_item(1'b1));
      pending_items.push_back(next_item(1'b1));
      settle();

      // Random phases: all-low, all-high-but-fitting, then random settings.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_settings(8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 16'd0);
            1: apply_settings(8'hff, 8'hff, 8'hff, 16'hfffe, 8'd240, 16'hffc0);
            default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                    16'($urandom), 8'($urandom), 16'($urandom));
         endcase
         repeat (PHASE_ITEMS) pending_items.push_back(next_item(1'b0));
         settle();
      end

      // Closing run: back at the reset bases, drain a stretch of entries with
      // rows still mixed in.
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                     RESET_YEAR_BASE, RESET_CITY_BASE, RESET_BRAND_BASE);
      repeat (SWEEP_DRAINS) begin
         pending_items.push_back(next_item(1'b1));
         if ($urandom_range(0, 3) == 0) pending_items.push_back(next_item(1'b0));
      end
      settle();

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filtered_group_sum_table.f
+incdir+sv
sv/fgst_pkg.sv
sv/fgst_chan_if.sv
sv/filtered_group_sum_table.sv
test/filtered_group_sum_table_test.sv
